>>> rtl/core/rwhp_pkg.sv
// ----------------------------------------------------------------------------
// rwhp_pkg: RIFF/WAVE header parser shared definitions
// Tags, status codes, parse phases, parser state and result word types.
// ----------------------------------------------------------------------------
package rwhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	// header length and minimum fmt body length
	localparam logic [4:0] HDR_LEN     = 5'd12;
	localparam logic [4:0] FMT_MIN_LEN = 5'd16;
	localparam logic [4:0] RIFF_LAST   = 5'd3;
	localparam logic [4:0] WAVE_LAST   = 5'd11;
	localparam logic [4:0] CHUNK_LAST  = 5'd7;
	localparam logic [4:0] TAG_BYTES   = 5'd4;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] CH_MONO   = 16'd1;
	localparam logic [15:0] CH_STEREO = 16'd2;
	localparam logic [15:0] BITS_8    = 16'd8;
	localparam logic [15:0] BITS_16   = 16'd16;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// result queue
	localparam int FIFO_AW    = 3;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_DATA,
		PH_SKIP,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK,
		ST_TOO_SMALL,
		ST_NO_RIFF,
		ST_NOT_WAVE,
		ST_FMT_PAST_END,
		ST_NOT_PCM,
		ST_CHANNELS,
		ST_BITS,
		ST_NO_FMT,
		ST_NO_DATA
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  pos;      // byte position, saturates past the fmt fields
		logic [32:0] rem;      // bytes left in the current body
		logic [31:0] tag;
		logic [15:0] fmt_tag;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [1:0]  found;    // bit0 fmt, bit1 data
		status_t     err;
		logic [31:0] pay_cnt;
		logic        pad;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{phase: PH_HEADER, err: ST_OK, default: '0};

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [3:0]  status;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		logic [31:0] payload_count;
	} result_t;

	typedef struct packed {
		logic [1:0] n;      // number of words pushed this cycle
		result_t    item0;
		result_t    item1;
	} push_t;

endpackage

>>> rtl/core/rwhp_in_if.sv
// ----------------------------------------------------------------------------
// rwhp_in_if: file byte channel
// Valid/ready channel carrying one file byte and its end-of-file flag.
// ----------------------------------------------------------------------------
interface rwhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       end_of_file;

	modport source(output valid, file_byte, end_of_file, input ready);
	modport sink(input valid, file_byte, end_of_file, output ready);
endinterface

>>> rtl/core/rwhp_out_if.sv
// ----------------------------------------------------------------------------
// rwhp_out_if: result channel
// Valid/ready channel carrying payload bytes and the final status word.
// ----------------------------------------------------------------------------
interface rwhp_out_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [7:0]  payload_byte;
	logic [3:0]  status;
	logic [15:0] channels;
	logic [31:0] sample_rate;
	logic [15:0] sample_bits;
	logic [31:0] payload_count;

	modport source(output valid, item_kind, payload_byte, status, channels, sample_rate,
		sample_bits, payload_count, input ready);
	modport sink(input valid, item_kind, payload_byte, status, channels, sample_rate,
		sample_bits, payload_count, output ready);
endinterface

>>> rtl/core/rwhp_step.sv
// ----------------------------------------------------------------------------
// rwhp_step: one-byte parser step
// Next parser state and up to two result words for one file byte.
// ----------------------------------------------------------------------------
module rwhp_step (
	input  rwhp_pkg::parse_state_t cur,
	input  logic [7:0]             file_byte,
	input  logic                   end_of_file,
	output rwhp_pkg::parse_state_t nxt,
	output rwhp_pkg::push_t        push
);

	function automatic rwhp_pkg::parse_state_t enter_hdr(rwhp_pkg::parse_state_t s);
		s.phase = rwhp_pkg::PH_CHUNK;
		s.pos   = '0;
		s.rem   = '0;
		s.tag   = '0;
		return s;
	endfunction

	function automatic rwhp_pkg::parse_state_t fail(rwhp_pkg::parse_state_t s,
			rwhp_pkg::status_t code);
		s.err   = code;
		s.phase = rwhp_pkg::PH_ERROR;
		return s;
	endfunction

	function automatic rwhp_pkg::parse_state_t end_body(rwhp_pkg::parse_state_t s);
		if (s.found == 2'b11) begin
			s.phase = rwhp_pkg::PH_DONE;
		end else if (s.pad) begin
			// consume the pad byte as a one-byte skip
			s.pad   = 1'b0;
			s.phase = rwhp_pkg::PH_SKIP;
			s.rem   = 33'd1;
		end else begin
			s = enter_hdr(s);
		end
		return s;
	endfunction

	function automatic rwhp_pkg::parse_state_t end_fmt(rwhp_pkg::parse_state_t s);
		if (s.pos < rwhp_pkg::FMT_MIN_LEN) begin
			s = fail(s, rwhp_pkg::ST_FMT_PAST_END);
		end else if (s.fmt_tag != rwhp_pkg::FMT_PCM) begin
			s = fail(s, rwhp_pkg::ST_NOT_PCM);
		end else if (s.chans != rwhp_pkg::CH_MONO && s.chans != rwhp_pkg::CH_STEREO) begin
			s = fail(s, rwhp_pkg::ST_CHANNELS);
		end else if (s.bits != rwhp_pkg::BITS_8 && s.bits != rwhp_pkg::BITS_16) begin
			s = fail(s, rwhp_pkg::ST_BITS);
		end else begin
			s.found[0] = 1'b1;
			s = end_body(s);
		end
		return s;
	endfunction

	function automatic rwhp_pkg::parse_state_t begin_body(rwhp_pkg::parse_state_t s);
		logic [31:0] size;
		size  = s.rem[31:0];
		s.pad = size[0];
		s.pos = '0;
		if (s.tag == rwhp_pkg::TAG_FMT) begin
			s.phase = rwhp_pkg::PH_FMT;
			if (size == '0) s = end_fmt(s);
		end else if (s.tag == rwhp_pkg::TAG_DATA && !s.found[1]) begin
			s.found[1] = 1'b1;
			s.phase    = rwhp_pkg::PH_DATA;
			if (size == '0) s = end_body(s);
		end else begin
			// unknown chunk or repeated data chunk: skip body and pad together
			s.rem   = {1'b0, size} + 33'(s.pad);
			s.pad   = 1'b0;
			s.phase = rwhp_pkg::PH_SKIP;
			if (s.rem == '0) s = end_body(s);
		end
		return s;
	endfunction

	rwhp_pkg::parse_state_t s;
	rwhp_pkg::result_t      stat_item;
	rwhp_pkg::result_t      pay_item;
	rwhp_pkg::status_t      st;
	logic [32:0]            rem_dec;
	logic                   has_pay;

	always_comb begin
		s        = cur;
		has_pay  = 1'b0;
		pay_item = '0;
		rem_dec  = cur.rem - 33'd1;

		case (cur.phase)
			rwhp_pkg::PH_HEADER: begin
				s.tag = {cur.tag[23:0], file_byte};
				s.pos = cur.pos + 5'd1;
				if (cur.pos == rwhp_pkg::RIFF_LAST && s.tag != rwhp_pkg::TAG_RIFF) begin
					s = fail(s, rwhp_pkg::ST_NO_RIFF);
				end else if (cur.pos == rwhp_pkg::WAVE_LAST) begin
					if (s.tag != rwhp_pkg::TAG_WAVE) s = fail(s, rwhp_pkg::ST_NOT_WAVE);
					else s = enter_hdr(s);
				end
			end
			rwhp_pkg::PH_CHUNK: begin
				if (cur.pos < rwhp_pkg::TAG_BYTES) begin
					s.tag = {cur.tag[23:0], file_byte};
				end else begin
					s.rem[{cur.pos[1:0], 3'b000} +: 8] =
						cur.rem[{cur.pos[1:0], 3'b000} +: 8] | file_byte;
				end
				s.pos = cur.pos + 5'd1;
				if (cur.pos >= rwhp_pkg::CHUNK_LAST) s = begin_body(s);
			end
			rwhp_pkg::PH_FMT: begin
				case (cur.pos) inside
					5'd0:          s.fmt_tag[7:0]  = file_byte;
					5'd1:          s.fmt_tag[15:8] = file_byte;
					5'd2:          s.chans[7:0]    = file_byte;
					5'd3:          s.chans[15:8]   = file_byte;
					[5'd4:5'd7]:   s.rate[{cur.pos[1:0], 3'b000} +: 8] = file_byte;
					5'd14:         s.bits[7:0]     = file_byte;
					5'd15:         s.bits[15:8]    = file_byte;
					default:       ;
				endcase
				// hold the position once past the last fmt field
				if (cur.pos < rwhp_pkg::FMT_MIN_LEN) s.pos = cur.pos + 5'd1;
				s.rem = rem_dec;
				if (rem_dec == '0) s = end_fmt(s);
			end
			rwhp_pkg::PH_DATA: begin
				has_pay                = 1'b1;
				pay_item.item_kind     = rwhp_pkg::KIND_PAYLOAD;
				pay_item.payload_byte  = file_byte;
				s.pay_cnt              = cur.pay_cnt + 32'd1;
				s.rem                  = rem_dec;
				if (rem_dec == '0) s = end_body(s);
			end
			rwhp_pkg::PH_SKIP: begin
				s.rem = rem_dec;
				if (rem_dec == '0) s = end_body(s);
			end
			rwhp_pkg::PH_ERROR: begin
				if (cur.pos < rwhp_pkg::HDR_LEN) s.pos = cur.pos + 5'd1;
			end
			default: ;
		endcase

		if (s.phase == rwhp_pkg::PH_HEADER) st = rwhp_pkg::ST_TOO_SMALL;
		else if (s.phase == rwhp_pkg::PH_ERROR)
			st = (s.err == rwhp_pkg::ST_NO_RIFF && s.pos < rwhp_pkg::HDR_LEN) ?
				rwhp_pkg::ST_TOO_SMALL : s.err;
		else if (s.phase == rwhp_pkg::PH_FMT) st = rwhp_pkg::ST_FMT_PAST_END;
		else if (!s.found[0]) st = rwhp_pkg::ST_NO_FMT;
		else if (!s.found[1]) st = rwhp_pkg::ST_NO_DATA;
		else st = rwhp_pkg::ST_OK;

		stat_item               = '0;
		stat_item.item_kind     = rwhp_pkg::KIND_STATUS;
		stat_item.status        = st;
		stat_item.channels      = s.chans;
		stat_item.sample_rate   = s.rate;
		stat_item.sample_bits   = s.bits;
		stat_item.payload_count = s.pay_cnt;

		push = '0;
		if (has_pay) begin
			push.item0 = pay_item;
			push.item1 = stat_item;
			push.n     = end_of_file ? 2'd2 : 2'd1;
		end else begin
			push.item0 = stat_item;
			push.item1 = stat_item;
			push.n     = end_of_file ? 2'd1 : 2'd0;
		end

		// drop all state after the final byte, ready for the next file
		nxt = end_of_file ? rwhp_pkg::PARSE_RESET : s;
	end

endmodule

>>> rtl/core/rwhp_result_fifo.sv
// ----------------------------------------------------------------------------
// rwhp_result_fifo: result word queue
// Small queue taking up to two words per cycle and giving one.
// ----------------------------------------------------------------------------
module rwhp_result_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rwhp_pkg::push_t              push,
	input  logic                         pop,
	output rwhp_pkg::result_t            head,
	output logic [rwhp_pkg::FIFO_AW:0]   count
);

	rwhp_pkg::result_t                 mem_q [rwhp_pkg::FIFO_DEPTH];
	logic [rwhp_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [rwhp_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [rwhp_pkg::FIFO_AW:0]        count_q;
	logic [rwhp_pkg::FIFO_AW-1:0]      wr_ptr_nx1;

	assign wr_ptr_nx1 = wr_ptr_q + rwhp_pkg::FIFO_AW'(1);
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_ptr_q]   <= push.item0;
		if (push.n == 2'd2) mem_q[wr_ptr_nx1] <= push.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rwhp_pkg::FIFO_AW'(push.n);
			if (pop) rd_ptr_q <= rd_ptr_q + rwhp_pkg::FIFO_AW'(1);
			count_q  <= count_q + (rwhp_pkg::FIFO_AW + 1)'(push.n)
				- (rwhp_pkg::FIFO_AW + 1)'(pop);
		end
	end

endmodule

>>> rtl/core/riff_wave_header_parser_core.sv
// ----------------------------------------------------------------------------
// riff_wave_header_parser_core: RIFF/WAVE PCM header parser
// Checks the WAV header, walks chunks, captures fmt fields, streams data.
// ----------------------------------------------------------------------------
// Usage:
//   file_ch takes the WAV file one byte per word, end_of_file set on the last
//   byte. result_ch gives payload words (item_kind 0) for each byte of the
//   first data chunk, then one status word (item_kind 1) on the final byte
//   with status, channels, sample_rate, sample_bits and payload_count.
//   On a nonzero status the consumer discards the payload already taken.
// Throughput:
//   One byte per cycle sustained while file_ch.ready stays high. A byte
//   accepted is registered in the input stage, then parsed and pushed
//   into the result queue, from which its words can be taken.
//   A data body byte that is also the last file byte pushes two words, its
//   payload word and the status word; the eight-word result queue absorbs that.
// Stall:
//   file_ch.ready drops only when the result queue could not take the words
//   of the byte in the input stage plus one more byte; a stalled result
//   word holds in the queue.
// Reset:
//   arst_n clears the parser to the RIFF header phase and empties the queue.
//   The parser also returns to that phase by itself after each final byte.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_core (
	input logic         clk,
	input logic         arst_n,
	rwhp_in_if.sink     file_ch,
	rwhp_out_if.source  result_ch
);

	// input stage
	logic       valid_s1;
	logic [7:0] file_byte_s1;
	logic       end_of_file_s1;

	rwhp_pkg::parse_state_t state_q;
	rwhp_pkg::parse_state_t state_nx;
	rwhp_pkg::push_t        step_push;
	rwhp_pkg::push_t        fifo_push;
	rwhp_pkg::result_t      head;
	logic [rwhp_pkg::FIFO_AW:0] fifo_count;
	logic [rwhp_pkg::FIFO_AW+1:0] fill_need;
	logic                   in_fire;
	logic                   out_fire;

	// reserve room for the byte in flight and the one being offered
	assign fill_need = (rwhp_pkg::FIFO_AW + 2)'(fifo_count)
		+ (valid_s1 ? (rwhp_pkg::FIFO_AW + 2)'(2) : '0)
		+ (rwhp_pkg::FIFO_AW + 2)'(2);
	assign file_ch.ready = fill_need <= (rwhp_pkg::FIFO_AW + 2)'(rwhp_pkg::FIFO_DEPTH);
	assign in_fire  = file_ch.valid && file_ch.ready;
	assign out_fire = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			file_byte_s1   <= file_ch.file_byte;
			end_of_file_s1 <= file_ch.end_of_file;
		end
	end

	rwhp_step u_step (
		.cur         (state_q),
		.file_byte   (file_byte_s1),
		.end_of_file (end_of_file_s1),
		.nxt         (state_nx),
		.push        (step_push)
	);

	// advance the parser only on a byte held in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwhp_pkg::PARSE_RESET;
		end else if (valid_s1) begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		fifo_push = step_push;
		if (!valid_s1) fifo_push.n = 2'd0;
	end

	rwhp_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.pop    (out_fire),
		.head   (head),
		.count  (fifo_count)
	);

	assign result_ch.valid         = fifo_count != '0;
	assign result_ch.item_kind     = head.item_kind;
	assign result_ch.payload_byte  = head.payload_byte;
	assign result_ch.status        = head.status;
	assign result_ch.channels      = head.channels;
	assign result_ch.sample_rate   = head.sample_rate;
	assign result_ch.sample_bits   = head.sample_bits;
	assign result_ch.payload_count = head.payload_count;

	// the queue never overflows under the ready rule
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= (rwhp_pkg::FIFO_AW + 1)'(rwhp_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// a payload word comes only from a byte parsed in the data phase
	a_pay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_push.n != 2'd0 && fifo_push.item0.item_kind == rwhp_pkg::KIND_PAYLOAD)
		|-> (valid_s1 && state_q.phase == rwhp_pkg::PH_DATA))
		else $error("payload word outside data phase");

	// the final byte returns the parser to the header phase with a clear count
	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_of_file_s1)
		|=> (state_q.phase == rwhp_pkg::PH_HEADER && state_q.pay_cnt == '0))
		else $error("parser not cleared after final byte");

	// the error phase always carries a latched error code
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == rwhp_pkg::PH_ERROR) |-> (state_q.err != rwhp_pkg::ST_OK))
		else $error("error phase without error code");

endmodule
